FILE: design/scrc_pkg.sv
// scrc_pkg: mode codes, constants and byte-wide crc update functions
// used by the selectable crc checksum block; no dependencies
package scrc_pkg;

	typedef enum logic [1:0] {
		MODE_CRC8  = 2'd0,
		MODE_CRC16 = 2'd1,
		MODE_CRC32 = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	localparam int unsigned CRC_W = 32;

	localparam logic [7:0]       CRC8_POLY  = 8'h07;
	localparam logic [15:0]      CRC16_POLY = 16'h1021;
	localparam logic [CRC_W-1:0] CRC32_POLY = 32'hEDB8_8320;
	localparam logic [CRC_W-1:0] CRC_INIT   = 32'hFFFF_FFFF;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] din);
		logic [7:0] c;
		c = crc ^ din;
		for (int b = 0; b < 8; b++) begin
			if (c[7])
				c = {c[6:0], 1'b0} ^ CRC8_POLY;
			else
				c = {c[6:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] din);
		logic [15:0] c;
		c = crc ^ {din, 8'h00};
		for (int b = 0; b < 8; b++) begin
			if (c[15])
				c = {c[14:0], 1'b0} ^ CRC16_POLY;
			else
				c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [CRC_W-1:0] crc32_step(input logic [CRC_W-1:0] crc,
		input logic [7:0] din);
		logic [CRC_W-1:0] c;
		c = crc ^ {24'h00_0000, din};
		for (int b = 0; b < 8; b++) begin
			if (c[0])
				c = {1'b0, c[CRC_W-1:1]} ^ CRC32_POLY;
			else
				c = {1'b0, c[CRC_W-1:1]};
		end
		return c;
	endfunction

endpackage

FILE: design/scrc_if.sv
// scrc_if: valid/ready stream interfaces for message bytes and checksums
// depends on nothing
interface scrc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface scrc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] checksum;

	modport source (output valid, output checksum, input ready);
	modport sink (input valid, input checksum, output ready);
endinterface

FILE: design/scrc_update.sv
// scrc_update: one byte folded into the running crc for the selected mode,
// plus the finished checksum; uses scrc_pkg
module scrc_update (
	input  scrc_pkg::mode_t mode,
	input  logic [31:0]     crc,
	input  logic [7:0]      din,
	output logic [31:0]     crc_next,
	output logic [31:0]     result
);
	import scrc_pkg::*;

	logic [7:0]       c8;
	logic [15:0]      c16;
	logic [CRC_W-1:0] c32;

	assign c8  = crc8_step(crc[7:0], din);
	assign c16 = crc16_step(crc[15:0], din);
	assign c32 = crc32_step(crc, din);

	always_comb begin
		unique case (mode)
			MODE_CRC8: begin
				crc_next = {crc[31:8], c8};
				result   = {24'h00_0000, c8};
			end
			MODE_CRC16: begin
				crc_next = {crc[31:16], c16};
				result   = {16'h0000, c16};
			end
			MODE_CRC32: begin
				crc_next = c32;
				result   = ~c32;
			end
			MODE_NONE: begin
				crc_next = crc;
				result   = '0;
			end
		endcase
	end
endmodule

FILE: design/scrc_out_stage.sv
// scrc_out_stage: result register holding a finished checksum until taken
// drives the output stream interface from scrc_if
module scrc_out_stage (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic [31:0] load_data,
	output logic        free,
	scrc_out_if.source  out_ch
);
	logic        valid_q;
	logic [31:0] checksum_q;

	assign free = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			checksum_q <= load_data;
		end
	end

	assign out_ch.valid    = valid_q;
	assign out_ch.checksum = checksum_q;
endmodule

FILE: design/selectable_crc_checksum.sv
// selectable_crc_checksum: top level of the crc8 / crc16 / crc32 engine
// uses scrc_pkg, scrc_if, scrc_update and scrc_out_stage
//
// usage:
//  - in_ch carries one message byte per item with last_byte marking the end
//    of the message; out_ch carries one 32-bit checksum per message
//  - cfg_wr_en / cfg_wr_data write the 2-bit mode (0 crc8, 1 crc16,
//    2 crc32, 3 gives zero); write it only while no message is in flight
//  - a byte is taken every cycle unless a last byte waits for a stalled out_ch;
//    it is registered, then folded into the running crc, and for a last byte
//    the checksum is loaded into the result register, where out_ch.valid rises
//  - the byte-wide crc update between the input and result registers sets
//    the rate of one item per cycle unless a last byte waits for out_ch
//  - reset clears all valid flags, loads the running crc with all ones and
//    selects crc32
//  - when out_ch stalls the result register holds; non-last bytes still
//    flow, a second last byte waits in the input register and in_ch.ready
//    drops only then
//  - the running crc is reloaded with all ones after each last byte
module selectable_crc_checksum (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_wr_data,
	scrc_in_if.sink    in_ch,
	scrc_out_if.source out_ch
);
	import scrc_pkg::*;

	mode_t            mode_q;
	logic [CRC_W-1:0] crc_q;
	logic             valid_s1;
	logic [7:0]       data_s1;
	logic             last_s1;
	logic [CRC_W-1:0] crc_next;
	logic [CRC_W-1:0] result;
	logic             out_free;
	logic             advance;

	assign advance     = valid_s1 && (!last_s1 || out_free);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CRC32;
		end else if (cfg_wr_en) begin
			mode_q <= mode_t'(cfg_wr_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			data_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (advance) begin
			crc_q <= last_s1 ? CRC_INIT : crc_next;
		end
	end

	scrc_update u_update (
		.mode     (mode_q),
		.crc      (crc_q),
		.din      (data_s1),
		.crc_next (crc_next),
		.result   (result)
	);

	scrc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && last_s1),
		.load_data (result),
		.free      (out_free),
		.out_ch    (out_ch)
	);
endmodule

FILE: design/scrc_checker.sv
// scrc_checker: port-level assertions for selectable_crc_checksum
// attached to the top level by the bind at the end of this file
module scrc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_checksum
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_checksum))
		else $error("stalled checksum changed or dropped");

	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
		else $error("checksum without a last item two cycles before");
endmodule

bind selectable_crc_checksum scrc_checker u_scrc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.in_last      (in_ch.last_byte),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_checksum (out_ch.checksum)
);
